/* sv/pcg32_pkg.sv */
// Shared types and constants for the PCG32 bounded random generator.
`timescale 1ns / 1ps
package pcg32_pkg;
    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;

    typedef enum logic [1:0] {
        ACT_RAW32   = 2'd0,
        ACT_RAW64   = 2'd1,
        ACT_BOUNDED = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // classified command passed from front to back
    typedef struct packed {
        action_t     action;
        logic        wide;   // bounded draw uses 64-bit candidates
        logic [63:0] limit;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAW_HI,
        ST_DRAW_LO,
        ST_FLOOR,
        ST_CHECK,
        ST_REDUCE,
        ST_OUT
    } state_t;

    function automatic logic [31:0] pcg_permute(input logic [63:0] s);
        logic [31:0] m;
        logic [4:0]  r;
        logic [63:0] x;
        x = s ^ (s >> 18);
        m = x[58:27];
        r = s[63:59];
        return (m >> r) | (m << ((6'd32 - {1'b0, r}) & 6'd31));
    endfunction
endpackage

/* sv/pcg32_front.sv */
// Front end: accepts requests, classifies them and feeds a two-entry queue.
`timescale 1ns / 1ps
module pcg32_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       action,
    input  logic [63:0]      limit,
    output logic             q_valid,
    input  logic             q_pop,
    output pcg32_pkg::cmd_t  q_cmd
);
    pcg32_pkg::cmd_t q_mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    pcg32_pkg::cmd_t in_cmd;
    logic            push;

    always_comb begin
        in_cmd.action = pcg32_pkg::action_t'(action);
        in_cmd.limit  = limit;
        in_cmd.wide   = (limit[63:32] != 32'd0);
        if (action == pcg32_pkg::ACT_BOUNDED && limit == 64'd0) begin
            in_cmd.action = pcg32_pkg::ACT_RAW64;
        end
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

/* sv/pcg32_div.sv */
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcg32_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] remainder
);
    logic [64:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next, div_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    assign remainder = rem_reg[63:0];
    assign done      = busy_reg && (cnt_reg == 7'd0);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[63:0], quo_reg[63]};
        if (start) begin
            rem_next  = 65'd0;
            quo_next  = dividend;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            quo_next = {quo_reg[62:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 7'd1;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            div_reg <= divisor;
        end
    end
endmodule

/* sv/pcg32_back.sv */
// Back end: generator state, draw sequencing, rejection test and output register.
`timescale 1ns / 1ps
module pcg32_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             seed_we,
    input  logic [63:0]      seed_wdata,
    input  logic             q_valid,
    output logic             q_pop,
    input  pcg32_pkg::cmd_t  q_cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata
);
    pcg32_pkg::state_t st_reg, st_next;
    logic [63:0] gen_reg, gen_next;
    logic [63:0] prod_reg;
    logic [63:0] cand_reg, cand_next;
    logic [63:0] floor_reg, floor_next;
    logic        floor_ok_reg, floor_ok_next;
    logic        hi_done_reg, hi_done_next;
    pcg32_pkg::cmd_t cmd_reg;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_reg, out_next;
    logic        load_cmd;
    logic [31:0] perm;
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_divisor, div_rem;
    logic [63:0] neg_lim;

    // 64x64 low product split into three 32x32 partial products
    logic [63:0] pp_ll, pp_lh, pp_hl;
    assign pp_ll = {32'd0, gen_reg[31:0]} * {32'd0, pcg32_pkg::PCG_MULT[31:0]};
    assign pp_lh = {32'd0, gen_reg[31:0]} * {32'd0, pcg32_pkg::PCG_MULT[63:32]};
    assign pp_hl = {32'd0, gen_reg[63:32]} * {32'd0, pcg32_pkg::PCG_MULT[31:0]};

    assign perm     = pcg32_pkg::pcg_permute(gen_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign neg_lim  = cmd_reg.wide ? (64'd0 - cmd_reg.limit)
                                   : {32'd0, 32'd0 - cmd_reg.limit[31:0]};
    assign div_divisor = cmd_reg.limit;

    pcg32_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        st_next        = st_reg;
        gen_next       = gen_reg;
        cand_next      = cand_reg;
        floor_next     = floor_reg;
        floor_ok_next  = floor_ok_reg;
        hi_done_next   = hi_done_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        load_cmd       = 1'b0;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = cand_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (st_reg)
            pcg32_pkg::ST_IDLE: begin
                if (q_valid) begin
                    load_cmd      = 1'b1;
                    q_pop         = 1'b1;
                    hi_done_next  = 1'b0;
                    floor_ok_next = 1'b0;
                    cand_next     = 64'd0;
                    if (q_cmd.action == pcg32_pkg::ACT_NONE) begin
                        st_next = pcg32_pkg::ST_OUT;
                    end else begin
                        st_next = pcg32_pkg::ST_MUL;
                    end
                end
            end
            pcg32_pkg::ST_MUL: begin
                st_next = pcg32_pkg::ST_DRAW_HI;
            end
            pcg32_pkg::ST_DRAW_HI: begin
                // prod_reg holds the state times multiplier
                gen_next = prod_reg + pcg32_pkg::PCG_INC;
                if (cmd_reg.action == pcg32_pkg::ACT_RAW32 ||
                    (cmd_reg.action == pcg32_pkg::ACT_BOUNDED && !cmd_reg.wide)) begin
                    cand_next = {32'd0, perm};
                    st_next   = pcg32_pkg::ST_DRAW_LO;
                    hi_done_next = 1'b1;
                end else if (!hi_done_reg) begin
                    cand_next    = {perm, 32'd0};
                    hi_done_next = 1'b1;
                    st_next      = pcg32_pkg::ST_MUL;
                end else begin
                    cand_next = {cand_reg[63:32], perm};
                    st_next   = pcg32_pkg::ST_DRAW_LO;
                end
            end
            pcg32_pkg::ST_DRAW_LO: begin
                // candidate complete
                if (cmd_reg.action == pcg32_pkg::ACT_BOUNDED) begin
                    if (floor_ok_reg) begin
                        st_next = pcg32_pkg::ST_CHECK;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = neg_lim;
                        st_next      = pcg32_pkg::ST_FLOOR;
                    end
                end else begin
                    st_next = pcg32_pkg::ST_OUT;
                end
            end
            pcg32_pkg::ST_FLOOR: begin
                if (div_done) begin
                    floor_next    = div_rem;
                    floor_ok_next = 1'b1;
                    st_next       = pcg32_pkg::ST_CHECK;
                end
            end
            pcg32_pkg::ST_CHECK: begin
                if (cand_reg >= floor_reg) begin
                    div_start = 1'b1;
                    st_next   = pcg32_pkg::ST_REDUCE;
                end else begin
                    // reject, draw again
                    hi_done_next = 1'b0;
                    st_next      = pcg32_pkg::ST_MUL;
                end
            end
            pcg32_pkg::ST_REDUCE: begin
                if (div_done) begin
                    cand_next = div_rem;
                    st_next   = pcg32_pkg::ST_OUT;
                end
            end
            pcg32_pkg::ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_next       = cand_reg;
                    st_next        = pcg32_pkg::ST_IDLE;
                end
            end
            default: st_next = pcg32_pkg::ST_IDLE;
        endcase
        if (seed_we) begin
            gen_next = seed_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= pcg32_pkg::ST_IDLE;
            gen_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
            floor_ok_reg  <= 1'b0;
            hi_done_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
            floor_ok_reg  <= floor_ok_next;
            hi_done_reg   <= hi_done_next;
        end
        prod_reg  <= pp_ll + {pp_lh[31:0] + pp_hl[31:0], 32'd0};
        cand_reg  <= cand_next;
        floor_reg <= floor_next;
        out_reg   <= out_next;
        if (load_cmd) begin
            cmd_reg <= q_cmd;
        end
    end
endmodule

/* sv/pcg32_bounded_random.sv */
// Top level of the PCG32 XSH-RR random generator with bounded draws.
// Usage:
//   Slave channel s_*: one request per transaction; tdata holds action
//   [1:0] and limit [65:2]. Master channel m_*: one 64-bit value per request.
//   seed_we/seed_wdata load the generator state; write only while idle.
// Sequencing:
//   Each 32-bit draw is a registered partial-product multiply, then a state
//   update. Bounded: the first candidate costs a remainder pass for the
//   rejection floor, each accepted candidate another remainder pass, and a
//   rejected candidate is drawn again. One request is worked on at a time,
//   set by the single back-end sequencer.
// Queueing:
//   A two-entry queue lets requests be accepted while the back end works,
//   and the output register lets one result wait while a stalled receiver
//   holds m_tready low; the back end then stops before its next result.
// Reset: generator state returns to zero and the sequencer to idle; queue and output are emptied.
module pcg32_bounded_random (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action [1:0], limit [65:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value [63:0]
    input  logic        seed_we,
    input  logic [63:0] seed_wdata
);
    logic            q_valid, q_pop;
    pcg32_pkg::cmd_t q_cmd;

    pcg32_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tdata[1:0]),
        .limit    (s_tdata[65:2]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    pcg32_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );
endmodule
